/* rtl/core/bapct_pkg.sv */
// Shared widths and conversion constants for the battery percent unit.
package bapct_pkg;

  localparam int unsigned SMP_W = 12;
  localparam int unsigned SUM_W = 15;
  localparam int unsigned CNT_W = 3;
  localparam int unsigned MV_W  = 13;
  localparam int unsigned PCT_W = 7;

  // Group average: sum * ceil(2^AVG_K / SAMPLES) >> AVG_K.
  localparam int unsigned AVG_K = 18;

  // Millivolts: floor(avg * 625 / 384) = floor(floor(avg * 625 / 128) / 3).
  localparam int unsigned PROD_W   = 22;
  localparam int unsigned MV_NUM   = 625;
  localparam int unsigned MV_SHIFT = 7;
  localparam int unsigned DIV3_K   = 17;
  localparam int unsigned DIV3_M   = 43691;

  // Percent curve break points.
  localparam int unsigned MV_FULL      = 4100;
  localparam int unsigned MV_KNEE      = 3335;
  localparam int unsigned MV_EMPTY     = 2900;
  localparam int unsigned KNEE_PERCENT = 15;
  localparam int unsigned FULL_PERCENT = 100;
  localparam int unsigned MV_MAX       = 6665;

  // Division by 9 and 29 of the small segment offsets.
  localparam int unsigned SEG_K   = 14;
  localparam int unsigned DIV9_M  = 1821;
  localparam int unsigned DIV29_M = 565;
  localparam int unsigned HI_W    = 10;
  localparam int unsigned LO_W    = 9;

endpackage

/* rtl/core/bapct_front.sv */
// Sample accumulator: sums each group and hands the finished sum on.
module bapct_front
  import bapct_pkg::*;
#(
  parameter int unsigned SAMPLES = 6
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [SMP_W-1:0] sample_i,
  input  logic             q_full_i,
  output logic             push_o,
  output logic [SUM_W-1:0] push_sum_o
);

  logic [SUM_W-1:0] sum_q, sum_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             last;
  logic             accept;

  assign last       = (cnt_q == CNT_W'(SAMPLES - 1));
  // Stall only the beat that closes a group, and only while the queue is full.
  assign in_ready_o = !(last && q_full_i);
  assign accept     = in_valid_i && in_ready_o;
  assign push_sum_o = SUM_W'(sum_q + SUM_W'(sample_i));
  assign push_o     = accept && last;

  always_comb begin
    sum_d = sum_q;
    cnt_d = cnt_q;
    if (accept) begin
      if (last) begin
        sum_d = '0;
        cnt_d = '0;
      end else begin
        sum_d = push_sum_o;
        cnt_d = CNT_W'(cnt_q + 1'b1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
      cnt_q <= '0;
    end else begin
      sum_q <= sum_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

/* rtl/core/bapct_fifo.sv */
// Two-entry queue carrying group sums from the accumulator to the converter.
module bapct_fifo
  import bapct_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [SUM_W-1:0] push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [SUM_W-1:0] data_o
);

  logic [SUM_W-1:0] mem_q [2];
  logic             wr_q, wr_d;
  logic             rd_q, rd_d;
  logic [1:0]       cnt_q, cnt_d;
  logic             do_push;
  logic             do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign data_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_d  = do_push ? !wr_q : wr_q;
    rd_d  = do_pop ? !rd_q : rd_q;
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = 2'(cnt_q + 1'b1);
    end else if (do_pop && !do_push) begin
      cnt_d = 2'(cnt_q - 1'b1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

/* rtl/core/bapct_back.sv */
// Conversion pipeline: average, millivolts and charge percent in four stages.
module bapct_back
  import bapct_pkg::*;
#(
  parameter int unsigned SAMPLES = 6
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             q_valid_i,
  input  logic [SUM_W-1:0] q_data_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [MV_W-1:0]  millivolts_o,
  output logic [PCT_W-1:0] percent_o
);

  localparam int unsigned AvgM   = ((1 << AVG_K) + SAMPLES - 1) / SAMPLES;
  localparam int unsigned AvgMW  = AVG_K + 1;
  localparam int unsigned AvgPW  = SUM_W + AvgMW;
  localparam int unsigned QW     = PROD_W - MV_SHIFT;
  localparam int unsigned D3PW   = 32;
  localparam int unsigned HiPW   = 21;
  localparam int unsigned LoPW   = 19;

  logic [3:0]         v_q, v_d;
  logic               adv;

  logic [AvgPW-1:0]   avg_prod;
  logic [SMP_W-1:0]   avg_q;
  logic [PROD_W-1:0]  prod_q, prod_d;
  logic [QW-1:0]      q_val;
  logic [D3PW-1:0]    d3_prod;
  logic [MV_W-1:0]    mv_q;
  logic [MV_W-1:0]    mv_out_q;
  logic [PCT_W-1:0]   pct_q, pct_d;
  logic [HI_W-1:0]    hi_off;
  logic [LO_W-1:0]    lo_off;
  logic [HiPW-1:0]    hi_prod;
  logic [LoPW-1:0]    lo_prod;

  // Advance the whole pipeline unless the output beat is held.
  assign adv   = !v_q[3] || out_ready_i;
  assign pop_o = adv && q_valid_i;
  assign v_d   = {v_q[2:0], q_valid_i};

  assign avg_prod = AvgPW'(q_data_i) * AvgPW'(AvgM);
  assign prod_d   = PROD_W'(avg_q) * PROD_W'(MV_NUM);
  assign q_val    = prod_q[PROD_W-1:MV_SHIFT];
  assign d3_prod  = D3PW'(q_val) * D3PW'(DIV3_M);

  assign hi_off  = HI_W'(mv_q - MV_W'(MV_KNEE));
  assign lo_off  = LO_W'(mv_q - MV_W'(MV_EMPTY));
  assign hi_prod = HiPW'(hi_off) * HiPW'(DIV9_M);
  assign lo_prod = LoPW'(lo_off) * LoPW'(DIV29_M);

  always_comb begin
    if (mv_q >= MV_W'(MV_FULL)) begin
      pct_d = PCT_W'(FULL_PERCENT);
    end else if (mv_q >= MV_W'(MV_KNEE)) begin
      pct_d = PCT_W'(PCT_W'(KNEE_PERCENT) + PCT_W'(hi_prod[HiPW-1:SEG_K]));
    end else if (mv_q >= MV_W'(MV_EMPTY)) begin
      pct_d = PCT_W'(lo_prod[LoPW-1:SEG_K]);
    end else begin
      pct_d = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      avg_q    <= avg_prod[AVG_K +: SMP_W];
      prod_q   <= prod_d;
      mv_q     <= d3_prod[DIV3_K +: MV_W];
      mv_out_q <= mv_q;
      pct_q    <= pct_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv) begin
      v_q <= v_d;
    end
  end

  assign out_valid_o  = v_q[3];
  assign millivolts_o = mv_out_q;
  assign percent_o    = pct_q;

endmodule

/* rtl/core/battery_adc_average_to_percent_unit.sv */
// Battery ADC averaging unit: top level joining accumulator, queue and converter.
//
// Input channel: one 12-bit ADC sample per beat on sample_i (in_valid_i/in_ready_o).
// Every SAMPLES beats the group sum is averaged with truncation, turned into
// millivolts as floor(avg*625/384) and mapped to a charge percent; one result
// beat carries millivolts_o and percent_o (out_valid_o/out_ready_i). Other
// input beats give no result.
// Throughput: one sample per cycle while in_ready_o is high; one result per
// cycle at most, set by the four-stage converter that advances every cycle the
// output is free. The sum of a group is written into the queue when the beat
// that closes it is taken, then passes the avg, prod, mv and pct registers.
// Stall: the output holds while out_ready_i is low and the converter freezes;
// two group sums queue behind it, after which only a group-closing beat is
// refused, so samples keep flowing in the meantime.
// Reset: the running sum, the sample count, the queue and all stage valids clear.
module battery_adc_average_to_percent_unit
  import bapct_pkg::*;
#(
  parameter int unsigned SAMPLES = 6
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [SMP_W-1:0] sample_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [MV_W-1:0]  millivolts_o,
  output logic [PCT_W-1:0] percent_o
);

  logic             q_full;
  logic             push;
  logic [SUM_W-1:0] push_sum;
  logic             pop;
  logic             q_valid;
  logic [SUM_W-1:0] q_data;

  bapct_front #(
    .SAMPLES(SAMPLES)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .sample_i  (sample_i),
    .q_full_i  (q_full),
    .push_o    (push),
    .push_sum_o(push_sum)
  );

  bapct_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(push_sum),
    .full_o     (q_full),
    .pop_i      (pop),
    .valid_o    (q_valid),
    .data_o     (q_data)
  );

  bapct_back #(
    .SAMPLES(SAMPLES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_data_i    (q_data),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .millivolts_o(millivolts_o),
    .percent_o   (percent_o)
  );

`ifndef SYNTH
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !q_full)
    else $error("group sum pushed into a full queue");

  a_pct_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (percent_o <= PCT_W'(FULL_PERCENT)) && (millivolts_o <= MV_W'(MV_MAX)))
    else $error("result out of range");

  a_pct_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (millivolts_o >= MV_W'(MV_FULL)) |-> percent_o == PCT_W'(FULL_PERCENT))
    else $error("full charge not reported as full percent");

  a_pct_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (millivolts_o < MV_W'(MV_EMPTY)) |-> percent_o == '0)
    else $error("empty battery reported with charge");
`endif

endmodule
